FILE: hw/rtl/prx_pkg.sv
// shared constants, types and operation codes of the polynomial root unit
`default_nettype none

package prx_pkg;

	// field and datapath widths
	localparam int VAL_W          = 64;
	localparam int OPD_W          = 32;
	localparam int B_W            = OPD_W + 1;
	localparam int IDX_W          = 4;
	localparam int DEG_W          = 5;
	localparam int ROOT_SLOTS     = 16;
	localparam int MAX_DEGREE_DEF = 16;

	// digit-serial multiplier split
	localparam int DIG_W = 16;
	localparam int N_DIG = VAL_W / DIG_W;
	localparam int ACC_W = VAL_W + B_W;

	// saturation bounds
	localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

	// what the multiply unit does with the saturated product
	typedef enum logic [1:0] {
		MS_PASS,
		MS_SUB,
		MS_ADD
	} ms_op_t;

	// command broadcast from the sequencer to every coefficient cell
	typedef struct packed {
		logic clear;
		logic shift;
		logic start;
		logic scale;
	} cell_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/prx_mulsat.sv
// digit-serial saturating 64x33 multiply with optional saturating add or subtract
`default_nettype none

module prx_mulsat (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	input  wire prx_pkg::ms_op_t                     op,
	input  wire logic signed [prx_pkg::VAL_W-1:0]    a,
	input  wire logic signed [prx_pkg::B_W-1:0]      b,
	input  wire logic signed [prx_pkg::VAL_W-1:0]    addend,
	output logic                                     done,
	output logic signed [prx_pkg::VAL_W-1:0]         result,
	output logic                                     ovf
);

	localparam int VW     = prx_pkg::VAL_W;
	localparam int BW     = prx_pkg::B_W;
	localparam int DW     = prx_pkg::DIG_W;
	localparam int AW     = prx_pkg::ACC_W;
	localparam int PPW    = DW + BW;
	localparam int DSEL_W = $clog2(prx_pkg::N_DIG);

	typedef enum logic [1:0] {
		S_IDLE,
		S_MUL,
		S_SAT,
		S_ACC
	} ms_state_t;

	ms_state_t               state_q;
	logic [DSEL_W-1:0]       dig_q;
	logic [VW-1:0]           ma_q;
	logic [BW-1:0]           mb_q;
	logic                    neg_q;
	prx_pkg::ms_op_t         op_q;
	logic [AW-1:0]           acc_q;
	logic signed [VW-1:0]    p_q;
	logic                    pov_q;

	logic [VW-1:0]           a_mag;
	logic [BW-1:0]           b_mag;
	logic [PPW-1:0]          pp;
	logic [AW-1:0]           pp_shift;
	logic [AW-1:0]           limit;
	logic                    over;
	logic [VW-1:0]           mag;
	logic signed [VW-1:0]    pv;
	logic signed [VW:0]      pe;
	logic signed [VW:0]      ae;
	logic signed [VW:0]      sum;
	logic                    sov;
	logic signed [VW-1:0]    sres;

	// operand magnitudes taken at start
	assign a_mag = a[VW-1] ? VW'(-a) : VW'(a);
	assign b_mag = b[BW-1] ? BW'(-b) : BW'(b);

	// one 16-bit digit of the magnitude per cycle
	assign pp       = ma_q[dig_q*DW +: DW] * mb_q;
	assign pp_shift = {{(AW-PPW){1'b0}}, pp} << (DW * dig_q);

	// saturate the signed product
	assign limit = neg_q ? (AW'(1) << (VW-1)) : ((AW'(1) << (VW-1)) - AW'(1));
	assign over  = acc_q > limit;
	assign mag   = acc_q[VW-1:0];
	assign pv    = over ? (neg_q ? prx_pkg::VAL_MIN : prx_pkg::VAL_MAX)
	                    : (neg_q ? VW'(-mag) : VW'(mag));

	// saturating add or subtract of the product
	assign pe = {p_q[VW-1], p_q};
	assign ae = {addend[VW-1], addend};
	always_comb begin
		case (op_q)
			prx_pkg::MS_SUB: sum = ae - pe;
			prx_pkg::MS_ADD: sum = ae + pe;
			default:         sum = pe;
		endcase
	end
	assign sov  = sum[VW] != sum[VW-1];
	assign sres = sov ? (sum[VW] ? prx_pkg::VAL_MIN : prx_pkg::VAL_MAX) : sum[VW-1:0];

	// sequencer and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done    <= 1'b0;
		end else begin
			done <= (state_q == S_ACC);
			case (state_q)
				S_IDLE: begin
					if (start) begin
						ma_q    <= a_mag;
						mb_q    <= b_mag;
						neg_q   <= a[VW-1] ^ b[BW-1];
						op_q    <= op;
						acc_q   <= '0;
						dig_q   <= '0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					acc_q <= acc_q + pp_shift;
					dig_q <= dig_q + DSEL_W'(1);
					if (dig_q == DSEL_W'(prx_pkg::N_DIG - 1)) begin
						state_q <= S_SAT;
					end
				end
				S_SAT: begin
					p_q     <= pv;
					pov_q   <= over;
					state_q <= S_ACC;
				end
				S_ACC: begin
					result  <= sres;
					ovf     <= pov_q | sov;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/prx_cell.sv
// one coefficient cell of the expansion chain
`default_nettype none

module prx_cell (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire prx_pkg::cell_ctrl_t               ctrl,
	input  wire logic signed [prx_pkg::B_W-1:0]    opnd,
	input  wire logic signed [prx_pkg::VAL_W-1:0]  prev_c,
	input  wire logic                              prev_ov,
	input  wire logic                              prev_live,
	output logic signed [prx_pkg::VAL_W-1:0]       c,
	output logic                                   ov,
	output logic                                   live,
	output logic                                   done
);

	logic signed [prx_pkg::VAL_W-1:0] c_q;
	logic                             ov_q;
	logic                             live_q;

	logic                             head;
	prx_pkg::ms_op_t                  ms_op;
	logic signed [prx_pkg::B_W-1:0]   ms_b;
	logic                             ms_done;
	logic signed [prx_pkg::VAL_W-1:0] ms_res;
	logic                             ms_ovf;

	// in a root step the lowest live cell multiplies by the negated root, the others subtract
	assign head  = live_q & ~prev_live;
	assign ms_op = (ctrl.scale || head) ? prx_pkg::MS_PASS : prx_pkg::MS_SUB;
	assign ms_b  = (!ctrl.scale && head) ? -opnd : opnd;

	prx_mulsat u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctrl.start),
		.op     (ms_op),
		.a      (c_q),
		.b      (ms_b),
		.addend (prev_c),
		.done   (ms_done),
		.result (ms_res),
		.ovf    (ms_ovf)
	);

	// coefficient update, neighbor copy and chain shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= 1'b0;
		end else if (ctrl.clear) begin
			live_q <= 1'b0;
		end else if (ctrl.shift) begin
			c_q    <= prev_c;
			ov_q   <= prev_ov;
			live_q <= prev_live;
		end else if (ms_done) begin
			if (ctrl.scale) begin
				if (live_q) begin
					c_q  <= ms_res;
					ov_q <= ov_q | ms_ovf;
				end
			end else if (live_q) begin
				c_q  <= ms_res;
				ov_q <= ov_q | (prev_live & prev_ov) | ms_ovf;
			end else if (prev_live) begin
				// new top coefficient inherits its lower neighbor
				c_q    <= prev_c;
				ov_q   <= prev_ov;
				live_q <= 1'b1;
			end
		end
	end

	assign c    = c_q;
	assign ov   = ov_q;
	assign live = live_q;
	assign done = ms_done;

endmodule

`default_nettype wire

FILE: hw/rtl/poly_roots_expand_and_eval_unit.sv
// top level: root table, coefficient cell chain, horner head and output register
//
// Input stream (s_*): one transaction per command. tuser carries the opcode
// (0 write root, 1 evaluate at operand, 2 dump coefficients); tdata carries
// root_index and operand. Output stream (m_*): tdata carries value and power,
// tuser the overflow flag, tlast marks the final result of a run.
// Configuration (cfg_*): index 0 leading coefficient, index 1 degree; write
// only while the block is idle. cfg_ready is always high.
// A root write gives no result. Evaluate and dump first rebuild the
// coefficients in a chain of MAX_DEGREE+1 cells, every cell with its own
// digit-serial multiplier: a root step for each root, then the scaling
// step, then shifts move the coefficients to the top cell. Evaluate then
// runs degree+1 Horner steps on the head multiplier. Dump gives degree+1
// results at the top cell, one per cycle while the receiver is ready.
// The results sit in an output register; a stalled receiver holds the dump
// or the finished result, and the next command is taken once the run has
// moved into that register. Reset clears the root table, sets the leading
// coefficient to 1 and the degree to 0.
`default_nettype none

module poly_roots_expand_and_eval_unit #(
	parameter int MAX_DEGREE = prx_pkg::MAX_DEGREE_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,   // root_index [3:0], operand [35:4]
	input  wire logic [1:0]  s_tuser,   // opcode [1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [71:0]      m_tdata,   // value [63:0], power [68:64]
	output logic [0:0]       m_tuser,   // overflow [0]
	output logic             m_tlast,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	localparam int VW    = prx_pkg::VAL_W;
	localparam int OW    = prx_pkg::OPD_W;
	localparam int BW    = prx_pkg::B_W;
	localparam int IW    = prx_pkg::IDX_W;
	localparam int GW    = prx_pkg::DEG_W;
	localparam int NCELL = MAX_DEGREE + 1;
	localparam int DW    = $clog2(MAX_DEGREE + 1);

	localparam logic [1:0] OP_WRITE_ROOT = 2'd0;
	localparam logic [1:0] OP_EVAL       = 2'd1;
	localparam logic [1:0] OP_DUMP       = 2'd2;

	localparam logic [0:0] CFG_LEADING = 1'd0;
	localparam logic [0:0] CFG_DEGREE  = 1'd1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_SEED,
		ST_EXP_GO,
		ST_EXP_WAIT,
		ST_SCALE_GO,
		ST_SCALE_WAIT,
		ST_ALIGN,
		ST_HORN_GO,
		ST_HORN_WAIT,
		ST_RESULT,
		ST_DUMP
	} state_t;

	state_t                state_q;
	logic [DW-1:0]         k_q;
	logic [DW-1:0]         pw_q;
	logic [DW-1:0]         align_q;
	logic                  is_eval_q;
	logic signed [OW-1:0]  x_q;
	logic signed [VW-1:0]  res_q;
	logic                  hov_q;
	logic                  out_valid_q;
	logic signed [VW-1:0]  out_value_q;
	logic [GW-1:0]         out_power_q;
	logic                  out_ovf_q;
	logic                  out_last_q;

	logic signed [OW-1:0]  lc_q;
	logic [GW-1:0]         degree_q;
	logic signed [OW-1:0]  root_q [prx_pkg::ROOT_SLOTS];

	logic                  in_acc;
	logic [1:0]            in_op;
	logic [IW-1:0]         in_idx;
	logic signed [OW-1:0]  in_opnd;
	logic [DW-1:0]         deg_use;
	logic [IW-1:0]         ridx;
	logic signed [OW-1:0]  root_rd;
	logic                  out_free;
	logic                  out_load;
	state_t                run_state;

	prx_pkg::cell_ctrl_t   ctrl;
	logic signed [BW-1:0]  cell_b;
	logic signed [VW-1:0]  cv [NCELL+1];
	logic [NCELL:0]        ovv;
	logic [NCELL:0]        lvv;
	logic [NCELL-1:0]      donev;
	logic [NCELL-1:0]      live_cells;
	logic                  done_all;
	logic signed [VW-1:0]  top_c;
	logic                  top_ov;

	logic                  h_done;
	logic signed [VW-1:0]  h_res;
	logic                  h_ovf;

	// input fields
	assign in_acc  = s_tvalid & s_tready;
	assign in_op   = s_tuser[1:0];
	assign in_idx  = s_tdata[IW-1:0];
	assign in_opnd = s_tdata[IW+OW-1:IW];

	// degree limited to the chain length
	assign deg_use = (int'(degree_q) > MAX_DEGREE) ? DW'(MAX_DEGREE) : DW'(degree_q);

	// configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lc_q     <= OW'(1);
			degree_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_LEADING: lc_q     <= cfg_data;
				CFG_DEGREE:  degree_q <= cfg_data[GW-1:0];
				default:     ;
			endcase
		end
	end

	// root table, slots from index MAX_DEGREE on stay zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < prx_pkg::ROOT_SLOTS; i++) begin
				root_q[i] <= '0;
			end
		end else if (in_acc && in_op == OP_WRITE_ROOT && int'(in_idx) < MAX_DEGREE) begin
			root_q[in_idx] <= in_opnd;
		end
	end

	assign ridx    = IW'(k_q);
	assign root_rd = (int'(k_q) < prx_pkg::ROOT_SLOTS) ? root_q[ridx] : '0;

	// broadcast commands to the cell chain
	assign out_free   = ~out_valid_q | m_tready;
	assign out_load   = out_free && ((state_q == ST_RESULT) || (state_q == ST_DUMP));
	assign ctrl.clear = state_q == ST_CLEAR;
	assign ctrl.start = (state_q == ST_EXP_GO) || (state_q == ST_SCALE_GO);
	assign ctrl.scale = (state_q == ST_SCALE_GO) || (state_q == ST_SCALE_WAIT);
	assign ctrl.shift = (state_q == ST_SEED) || (state_q == ST_ALIGN)
	                 || (state_q == ST_HORN_WAIT && h_done)
	                 || (state_q == ST_DUMP && out_free);
	assign cell_b     = ctrl.scale ? {lc_q[OW-1], lc_q} : {root_rd[OW-1], root_rd};

	// chain head feeds the seed coefficient of one
	assign cv[0]  = (state_q == ST_SEED) ? VW'(1) : '0;
	assign ovv[0] = 1'b0;
	assign lvv[0] = state_q == ST_SEED;

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		prx_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.opnd      (cell_b),
			.prev_c    (cv[i]),
			.prev_ov   (ovv[i]),
			.prev_live (lvv[i]),
			.c         (cv[i+1]),
			.ov        (ovv[i+1]),
			.live      (lvv[i+1]),
			.done      (donev[i])
		);
	end

	assign live_cells = lvv[NCELL:1];
	assign done_all   = &donev;
	assign top_c      = cv[NCELL];
	assign top_ov     = ovv[NCELL];

	// horner head
	prx_mulsat u_horner (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_HORN_GO),
		.op     (prx_pkg::MS_ADD),
		.a      (res_q),
		.b      ({x_q[OW-1], x_q}),
		.addend (top_c),
		.done   (h_done),
		.result (h_res),
		.ovf    (h_ovf)
	);

	assign run_state = is_eval_q ? ST_HORN_GO : ST_DUMP;
	assign s_tready  = state_q == ST_IDLE;

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (in_op)
							OP_EVAL: begin
								x_q       <= in_opnd;
								is_eval_q <= 1'b1;
								state_q   <= ST_CLEAR;
							end
							OP_DUMP: begin
								is_eval_q <= 1'b0;
								state_q   <= ST_CLEAR;
							end
							default: ;
						endcase
					end
				end
				ST_CLEAR: state_q <= ST_SEED;
				ST_SEED: begin
					k_q     <= '0;
					state_q <= (deg_use == '0) ? ST_SCALE_GO : ST_EXP_GO;
				end
				ST_EXP_GO: state_q <= ST_EXP_WAIT;
				ST_EXP_WAIT: begin
					if (done_all) begin
						k_q     <= k_q + DW'(1);
						state_q <= (k_q == deg_use - DW'(1)) ? ST_SCALE_GO : ST_EXP_GO;
					end
				end
				ST_SCALE_GO: state_q <= ST_SCALE_WAIT;
				ST_SCALE_WAIT: begin
					if (done_all) begin
						pw_q    <= deg_use;
						res_q   <= '0;
						hov_q   <= 1'b0;
						align_q <= DW'(MAX_DEGREE) - deg_use;
						state_q <= (deg_use == DW'(MAX_DEGREE)) ? run_state : ST_ALIGN;
					end
				end
				ST_ALIGN: begin
					align_q <= align_q - DW'(1);
					if (align_q == DW'(1)) begin
						state_q <= run_state;
					end
				end
				ST_HORN_GO: state_q <= ST_HORN_WAIT;
				ST_HORN_WAIT: begin
					if (h_done) begin
						res_q <= h_res;
						hov_q <= hov_q | h_ovf | top_ov;
						if (pw_q == '0) begin
							state_q <= ST_RESULT;
						end else begin
							pw_q    <= pw_q - DW'(1);
							state_q <= ST_HORN_GO;
						end
					end
				end
				ST_RESULT: begin
					if (out_free) begin
						out_value_q <= res_q;
						out_power_q <= '0;
						out_ovf_q   <= hov_q;
						out_last_q  <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				ST_DUMP: begin
					if (out_free) begin
						out_value_q <= top_c;
						out_power_q <= GW'(pw_q);
						out_ovf_q   <= top_ov;
						out_last_q  <= pw_q == '0;
						if (pw_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							pw_q <= pw_q - DW'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output stream
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_power_q, out_value_q};
	assign m_tuser  = out_ovf_q;
	assign m_tlast  = out_last_q;

	// all cells run their multipliers in lock step
	a_cells_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(|donev) |-> (&donev))
		else $error("coefficient cells out of step");

	// live cells form a run starting at cell zero while expanding
	a_live_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXP_WAIT) |->
		(live_cells[0] && ((live_cells & (live_cells + 1'b1)) == '0)))
		else $error("live cells not contiguous from the bottom");

	// seeding makes the bottom cell live
	a_seed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEED) |=> live_cells[0])
		else $error("seed did not reach the bottom cell");

	// the horner head finishes only while it is awaited
	a_horner_done: assert property (@(posedge clk) disable iff (!arst_n)
		h_done |-> (state_q == ST_HORN_WAIT))
		else $error("unexpected horner completion");

	// the final result of a run always has power zero
	a_last_power: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (m_tdata[68:64] == 5'd0))
		else $error("last result with nonzero power");

endmodule

`default_nettype wire
